FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; define NO_ASSERTIONS to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked implication check, quiet during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/igmp_pfp_pkg.sv
// Package for the IGMP field parser: field codes, result item type,
// sizing defaults and the floating code decoder. No dependencies.
`default_nettype none
package igmp_pfp_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int MAX_ITEMS       = 4;

  // Message types
  localparam logic [7:0] T_QUERY     = 8'h11;
  localparam logic [7:0] T_V1_REPORT = 8'h12;
  localparam logic [7:0] T_V2_REPORT = 8'h16;
  localparam logic [7:0] T_LEAVE     = 8'h17;
  localparam logic [7:0] T_V3_REPORT = 8'h22;

  // Field codes
  localparam logic [4:0] F_TYPE      = 5'd0;
  localparam logic [4:0] F_VERSION   = 5'd1;
  localparam logic [4:0] F_CHECKSUM  = 5'd2;
  localparam logic [4:0] F_CSUM_OK   = 5'd3;
  localparam logic [4:0] F_RESP_CODE = 5'd4;
  localparam logic [4:0] F_RESP_TIME = 5'd5;
  localparam logic [4:0] F_RESERVED  = 5'd6;
  localparam logic [4:0] F_GROUP     = 5'd7;
  localparam logic [4:0] F_SUPPRESS  = 5'd8;
  localparam logic [4:0] F_QRV       = 5'd9;
  localparam logic [4:0] F_QQIC      = 5'd10;
  localparam logic [4:0] F_INTERVAL  = 5'd11;
  localparam logic [4:0] F_SRC_COUNT = 5'd12;
  localparam logic [4:0] F_SRC_ADDR  = 5'd13;
  localparam logic [4:0] F_REC_COUNT = 5'd14;
  localparam logic [4:0] F_REC_START = 5'd15;
  localparam logic [4:0] F_REC_TYPE  = 5'd16;
  localparam logic [4:0] F_AUX_LEN   = 5'd17;
  localparam logic [4:0] F_REC_NSRC  = 5'd18;
  localparam logic [4:0] F_REC_GROUP = 5'd19;
  localparam logic [4:0] F_REC_SRC   = 5'd20;
  localparam logic [4:0] F_AUX_BYTE  = 5'd21;
  localparam logic [4:0] F_TRAILING  = 5'd22;
  localparam logic [4:0] F_END       = 5'd23;

  typedef struct packed {
    logic        malformed;
    logic [15:0] offset;
    logic [31:0] value;
    logic [4:0]  code;
  } item_t;

  function automatic item_t mk_item(logic [4:0] code, logic [31:0] value,
                                    logic [15:0] offset);
    item_t it;
    it.code      = code;
    it.value     = value;
    it.offset    = offset;
    it.malformed = 1'b0;
    return it;
  endfunction

  // Max response / querier interval floating code
  function automatic logic [31:0] float_decode(logic [7:0] c);
    logic [14:0] m;
    m = {10'd0, 1'b1, c[3:0]} << ({1'b0, c[6:4]} + 4'd3);
    return c[7] ? {17'd0, m} : {24'd0, c};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/igmp_packet_field_parser_unit.sv
// IGMP message field parser, top level: byte parser and result queue.
// Depends on igmp_pfp_pkg and assert_macros.svh.
//
// Accepts one message byte per cycle while s_tready is high and turns it into
// zero to four field requests (type, header fields, sources, group records,
// checksum verdict, end marker) that leave one per cycle while m_tready is
// high, through an eight-entry result queue. Input tready is high while the
// queue has room for four results, so bytes flow at one per cycle as long as
// results drain as fast as they arrive; bytes that yield several results
// (query flags byte, message end) take longer to drain, absorbed by the
// queue. Each byte's results enter the queue behind any still waiting there.
`default_nettype none
`include "assert_macros.svh"
module igmp_packet_field_parser_unit #(
  parameter int LENGTH_BITS = igmp_pfp_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = igmp_pfp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [55:0] m_tdata,   // [4:0] field_code, [36:5] field_value,
                                      // [52:37] field_offset, [53] malformed
  output      logic        m_tlast    // last_of_run
);
  import igmp_pfp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LENGTH_BITS-1:0] OFF_MAX = '1;

  typedef enum logic [3:0] {
    PH_TYPE, PH_HEAD, PH_QSRC, PH_RHA, PH_RHB, PH_RSRC, PH_RAUX,
    PH_TRAIL, PH_UNKNOWN
  } phase_t;

  // Parser state
  logic [LENGTH_BITS-1:0] byte_offset;
  phase_t                 parse_phase;
  logic [7:0]             message_type;
  logic [7:0]             resp_byte;
  logic [16:0]            checksum_sum;
  logic [15:0]            records_left;
  logic [15:0]            sources_left;
  logic [9:0]             aux_left;
  logic [31:0]            value_collect;
  logic                   malformed_seen;
  logic                   parse_stopped;

  logic [LENGTH_BITS-1:0] byte_offset_next;
  phase_t                 parse_phase_next;
  logic [7:0]             message_type_next;
  logic [16:0]            checksum_sum_next;
  logic [15:0]            records_left_next;
  logic [15:0]            sources_left_next;
  logic [9:0]             aux_left_next;
  logic [31:0]            value_collect_next;
  logic                   malformed_seen_next;
  logic                   parse_stopped_next;

  item_t      items [MAX_ITEMS];
  logic [2:0] n_items;

  // Result queue
  item_t         qmem [QUEUE_DEPTH];
  logic          qlast [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic in_fire, out_fire;
  assign s_tready = (count <= CW'(QUEUE_DEPTH - MAX_ITEMS));
  assign in_fire  = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign out_fire = m_tvalid && m_tready;
  assign m_tdata  = {2'b00, qmem[rd_ptr]};
  assign m_tlast  = qlast[rd_ptr];

  // Per-byte parse: next state and up to four results
  always_comb begin
    logic [7:0]  b;
    logic [15:0] off;
    logic [16:0] s;
    logic        query, ok, clean;
    logic [15:0] rl_dec;
    logic        mal_body;
    logic [2:0]  n_body;
    b   = s_tdata;
    off = 16'(byte_offset);
    query = (message_type == T_QUERY);
    byte_offset_next    = byte_offset;
    parse_phase_next    = parse_phase;
    message_type_next   = message_type;
    checksum_sum_next   = checksum_sum;
    records_left_next   = records_left;
    sources_left_next   = sources_left;
    aux_left_next       = aux_left;
    value_collect_next  = value_collect;
    malformed_seen_next = malformed_seen;
    parse_stopped_next  = parse_stopped;
    n_items = 3'd0;
    for (int i = 0; i < MAX_ITEMS; i++) items[i] = mk_item(F_TYPE, '0, '0);
    s = '0; ok = 1'b0; clean = 1'b0;
    rl_dec = records_left - 16'd1;

    if (parse_stopped) begin
      malformed_seen_next = 1'b1;
    end else begin
      s = checksum_sum + (off[0] ? {9'd0, b} : {1'b0, b, 8'd0});
      checksum_sum_next  = {16'd0, s[16]} + {1'b0, s[15:0]};
      value_collect_next = {value_collect[23:0], b};
      case (parse_phase)
        PH_TYPE: begin
          message_type_next = b;
          items[0] = mk_item(F_TYPE, {24'd0, b}, 16'd0);
          n_items = 3'd1;
          parse_phase_next = PH_HEAD;
          if (b == T_V1_REPORT) begin
            items[1] = mk_item(F_VERSION, 32'd1, 16'd0); n_items = 3'd2;
          end else if (b == T_V2_REPORT || b == T_LEAVE) begin
            items[1] = mk_item(F_VERSION, 32'd2, 16'd0); n_items = 3'd2;
          end else if (b == T_V3_REPORT) begin
            items[1] = mk_item(F_VERSION, 32'd3, 16'd0); n_items = 3'd2;
          end else if (b != T_QUERY) begin
            parse_phase_next = PH_UNKNOWN;
          end
        end
        PH_HEAD: begin
          if (off == 16'd1) begin
            if (query) begin
              items[0] = mk_item(F_RESP_CODE, {24'd0, b}, 16'd1);
              items[1] = mk_item(F_RESP_TIME, float_decode(b), 16'd1);
              n_items = 3'd2;
            end else begin
              if (b != 8'd0) malformed_seen_next = 1'b1;
              items[0] = mk_item(F_RESERVED, {24'd0, b}, 16'd1);
              n_items = 3'd1;
            end
          end else if (off == 16'd3) begin
            items[0] = mk_item(F_CHECKSUM, {16'd0, value_collect_next[15:0]}, 16'd2);
            n_items = 3'd1;
          end else if (off == 16'd5 && message_type == T_V3_REPORT) begin
            if (value_collect_next[15:0] != 16'd0) malformed_seen_next = 1'b1;
            items[0] = mk_item(F_RESERVED, {16'd0, value_collect_next[15:0]}, 16'd4);
            n_items = 3'd1;
          end else if (off == 16'd7) begin
            if (message_type == T_V3_REPORT) begin
              records_left_next = value_collect_next[15:0];
              items[0] = mk_item(F_REC_COUNT, {16'd0, value_collect_next[15:0]}, 16'd6);
              n_items = 3'd1;
              parse_phase_next = (value_collect_next[15:0] != 16'd0) ? PH_RHA : PH_TRAIL;
            end else begin
              items[0] = mk_item(F_GROUP, value_collect_next, 16'd4);
              n_items = 3'd1;
              if (query) begin
                items[1] = mk_item(F_VERSION,
                  s_tlast ? ((resp_byte == 8'd0) ? 32'd1 : 32'd2) : 32'd3, 16'd0);
                n_items = 3'd2;
              end
              parse_phase_next = (query && !s_tlast) ? PH_HEAD : PH_TRAIL;
            end
          end else if (off == 16'd8) begin
            if (b[7:4] != 4'd0) malformed_seen_next = 1'b1;
            items[0] = mk_item(F_RESERVED, {28'd0, b[7:4]}, 16'd8);
            items[1] = mk_item(F_SUPPRESS, {31'd0, b[3]}, 16'd8);
            items[2] = mk_item(F_QRV, {29'd0, b[2:0]}, 16'd8);
            n_items = 3'd3;
          end else if (off == 16'd9) begin
            items[0] = mk_item(F_QQIC, {24'd0, b}, 16'd9);
            items[1] = mk_item(F_INTERVAL, float_decode(b), 16'd9);
            n_items = 3'd2;
          end else if (off == 16'd11) begin
            sources_left_next = value_collect_next[15:0];
            items[0] = mk_item(F_SRC_COUNT, {16'd0, value_collect_next[15:0]}, 16'd10);
            n_items = 3'd1;
            parse_phase_next = (value_collect_next[15:0] != 16'd0) ? PH_QSRC : PH_TRAIL;
          end
        end
        PH_QSRC: begin
          if (off[1:0] == 2'd3) begin
            items[0] = mk_item(F_SRC_ADDR, value_collect_next, off - 16'd3);
            n_items = 3'd1;
            sources_left_next = sources_left - 16'd1;
            if (sources_left == 16'd1) parse_phase_next = PH_TRAIL;
          end
        end
        PH_RHA: begin
          if (off[1:0] == 2'd0) begin
            if (b < 8'd1 || b > 8'd6) malformed_seen_next = 1'b1;
            items[0] = mk_item(F_REC_START, {16'd0, records_left}, off);
            items[1] = mk_item(F_REC_TYPE, {24'd0, b}, off);
            n_items = 3'd2;
          end else if (off[1:0] == 2'd1) begin
            aux_left_next = {b, 2'b00};
            items[0] = mk_item(F_AUX_LEN, {22'd0, b, 2'b00}, off);
            n_items = 3'd1;
          end else if (off[1:0] == 2'd3) begin
            sources_left_next = value_collect_next[15:0];
            items[0] = mk_item(F_REC_NSRC, {16'd0, value_collect_next[15:0]},
                               off - 16'd1);
            n_items = 3'd1;
            parse_phase_next = PH_RHB;
          end
        end
        PH_RHB, PH_RSRC: begin
          if (off[1:0] == 2'd3) begin
            items[0] = mk_item((parse_phase == PH_RHB) ? F_REC_GROUP : F_REC_SRC,
                               value_collect_next, off - 16'd3);
            n_items = 3'd1;
            if (parse_phase == PH_RHB && sources_left != 16'd0) begin
              parse_phase_next = PH_RSRC;
            end else if (parse_phase == PH_RSRC && sources_left != 16'd1) begin
              sources_left_next = sources_left - 16'd1;
            end else begin
              if (parse_phase == PH_RSRC) sources_left_next = 16'd0;
              if (aux_left != 10'd0) begin
                parse_phase_next = PH_RAUX;
              end else begin
                records_left_next = rl_dec;
                parse_phase_next  = (rl_dec != 16'd0) ? PH_RHA : PH_TRAIL;
              end
            end
          end
        end
        PH_RAUX: begin
          items[0] = mk_item(F_AUX_BYTE, {24'd0, b}, off);
          n_items = 3'd1;
          aux_left_next = aux_left - 10'd1;
          if (aux_left == 10'd1) begin
            records_left_next = rl_dec;
            parse_phase_next  = (rl_dec != 16'd0) ? PH_RHA : PH_TRAIL;
          end
        end
        PH_TRAIL: begin
          malformed_seen_next = 1'b1;
          items[0] = mk_item(F_TRAILING, {24'd0, b}, off);
          n_items = 3'd1;
        end
        default: begin
          items[0] = mk_item(F_TRAILING, {24'd0, b}, off);
          n_items = 3'd1;
        end
      endcase
    end

    // Field results carry the flag as it stands before the end checks
    mal_body = malformed_seen_next;
    n_body   = n_items;

    // Message end: checksum verdict and end marker
    if (s_tlast) begin
      clean = !parse_stopped &&
              (parse_phase_next == PH_TRAIL || parse_phase_next == PH_UNKNOWN);
      if (!clean) begin
        malformed_seen_next = 1'b1;
      end else if (parse_phase_next == PH_TRAIL) begin
        s  = {16'd0, checksum_sum_next[16]} + {1'b0, checksum_sum_next[15:0]};
        s  = {16'd0, s[16]} + {1'b0, s[15:0]};
        ok = (s == 17'h0FFFF);
        if (!ok) malformed_seen_next = 1'b1;
        items[n_items[1:0]] = mk_item(F_CSUM_OK, {31'd0, ok}, 16'd2);
        n_items = n_items + 3'd1;
      end
      items[n_items[1:0]] = mk_item(F_END, 32'(byte_offset) + 32'd1, off);
      n_items = n_items + 3'd1;
    end else if (!parse_stopped) begin
      if (byte_offset == OFF_MAX) parse_stopped_next = 1'b1;
      else byte_offset_next = byte_offset + 1'b1;
    end

    // Checksum verdict and end marker see the final flag
    for (int i = 0; i < MAX_ITEMS; i++)
      items[i].malformed = (3'(i) < n_body) ? mal_body : malformed_seen_next;
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst || (in_fire && s_tlast)) begin
      byte_offset    <= '0;
      parse_phase    <= PH_TYPE;
      message_type   <= '0;
      checksum_sum   <= '0;
      records_left   <= '0;
      sources_left   <= '0;
      aux_left       <= '0;
      value_collect  <= '0;
      malformed_seen <= 1'b0;
      parse_stopped  <= 1'b0;
    end else if (in_fire) begin
      byte_offset    <= byte_offset_next;
      parse_phase    <= parse_phase_next;
      message_type   <= message_type_next;
      checksum_sum   <= checksum_sum_next;
      records_left   <= records_left_next;
      sources_left   <= sources_left_next;
      aux_left       <= aux_left_next;
      value_collect  <= value_collect_next;
      malformed_seen <= malformed_seen_next;
      parse_stopped  <= parse_stopped_next;
    end
  end

  // Held response code byte, tells v1 from v2 queries
  always_ff @(posedge clk) begin
    if (in_fire && !parse_stopped && byte_offset == LENGTH_BITS'(1)) begin
      resp_byte <= s_tdata;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
        if (3'(i) < n_items) begin
          qmem[wr_ptr + PW'(i)]  <= items[i];
          qlast[wr_ptr + PW'(i)] <= (3'(i + 1) == n_items);
        end
      end
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) wr_ptr <= wr_ptr + PW'(n_items);
      if (out_fire) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (in_fire ? CW'(n_items) : CW'(0)) - (out_fire ? CW'(1) : CW'(0));
    end
  end

  // Checks
  `ASSERT_CLK(a_queue_bound, clk, rst, count <= CW'(QUEUE_DEPTH), "result queue overflow")
  `ASSERT_CLK(a_end_resets, clk, rst, in_fire && s_tlast |=> byte_offset == '0 && !parse_stopped, "message state not cleared after end")
  `ASSERT_CLK(a_stop_at_max, clk, rst, parse_stopped |-> byte_offset == OFF_MAX, "parser stopped below maximum offset")

endmodule
`default_nettype wire

FILE: tb/igmp_packet_field_parser_unit_tb.sv
// Testbench for the IGMP field parser: drives message bytes, predicts the
// field items in a scoreboard class and checks every result. Needs igmp_pfp_pkg.
`timescale 1ns / 100ps
`default_nettype none
module igmp_packet_field_parser_unit_tb;
  import igmp_pfp_pkg::*;

  localparam int OFF_LAST = 65535;
  localparam int WD_LIMIT = 5000;

  typedef enum int {
    PH_TYPE, PH_HEAD, PH_QSRC, PH_RHA, PH_RHB, PH_RSRC, PH_RAUX, PH_TRAIL, PH_UNKNOWN
  } phase_e;

  typedef struct packed {
    logic        is_last;
    logic        malformed;
    logic [15:0] offset;
    logic [31:0] value;
    logic [4:0]  code;
  } field_t;

  // Field predictor and pending-field store
  class field_board;
    field_t      pending[$];
    int          errors;
    int          shown;
    logic [31:0] off;
    phase_e      phase;
    logic [7:0]  mtype;
    logic [7:0]  hold[12];
    logic [31:0] sum;
    logic [15:0] recs, srcs;
    logic [9:0]  aux;
    logic [31:0] acc;
    logic        bad, stopped;
    field_t      run[$];

    function void clear_msg();
      off = 0; phase = PH_TYPE; mtype = 0; sum = 0; recs = 0; srcs = 0;
      aux = 0; acc = 0; bad = 0; stopped = 0;
    endfunction

    function new();
      errors = 0; shown = 0;
      clear_msg();
    endfunction

    function void put(logic [4:0] c, logic [31:0] v, logic [31:0] o);
      field_t f;
      if (run.size() >= MAX_ITEMS) return;
      f.code = c; f.value = v; f.offset = o[15:0]; f.malformed = bad; f.is_last = 0;
      run.push_back(f);
    endfunction

    function logic [31:0] fdecode(logic [7:0] c);
      if (!c[7]) return {24'd0, c};
      return ({28'd0, c[3:0]} | 32'h10) << (c[6:4] + 3);
    endfunction

    function void rec_done();
      recs = recs - 1;
      phase = (recs != 0) ? PH_RHA : PH_TRAIL;
    endfunction

    function void src_done();
      if (aux != 0) phase = PH_RAUX;
      else rec_done();
    endfunction

    function void head(logic [31:0] o, logic [7:0] b, logic lst);
      logic q;
      q = (mtype == T_QUERY);
      if (o == 1) begin
        if (q) begin
          put(F_RESP_CODE, b, 1); put(F_RESP_TIME, fdecode(b), 1);
        end else begin
          if (b != 0) bad = 1;
          put(F_RESERVED, b, 1);
        end
      end else if (o == 3) begin
        put(F_CHECKSUM, acc[15:0], 2);
      end else if (o == 5 && mtype == T_V3_REPORT) begin
        if (acc[15:0] != 0) bad = 1;
        put(F_RESERVED, acc[15:0], 4);
      end else if (o == 7) begin
        if (mtype == T_V3_REPORT) begin
          recs = acc[15:0];
          put(F_REC_COUNT, recs, 6);
          phase = (recs != 0) ? PH_RHA : PH_TRAIL;
        end else begin
          put(F_GROUP, acc, 4);
          if (q) put(F_VERSION, lst ? ((hold[1] == 0) ? 1 : 2) : 3, 0);
          phase = (q && !lst) ? PH_HEAD : PH_TRAIL;
        end
      end else if (o == 8) begin
        if (b[7:4] != 0) bad = 1;
        put(F_RESERVED, b[7:4], 8); put(F_SUPPRESS, b[3], 8); put(F_QRV, b[2:0], 8);
      end else if (o == 9) begin
        put(F_QQIC, b, 9); put(F_INTERVAL, fdecode(b), 9);
      end else if (o == 11) begin
        srcs = acc[15:0];
        put(F_SRC_COUNT, srcs, 10);
        phase = (srcs != 0) ? PH_QSRC : PH_TRAIL;
      end
    endfunction

    function void parse(logic [31:0] o, logic [7:0] b, logic lst);
      case (phase)
        PH_TYPE: begin
          mtype = b; put(F_TYPE, b, 0); phase = PH_HEAD;
          if (b == T_V1_REPORT) put(F_VERSION, 1, 0);
          else if (b == T_V2_REPORT || b == T_LEAVE) put(F_VERSION, 2, 0);
          else if (b == T_V3_REPORT) put(F_VERSION, 3, 0);
          else if (b != T_QUERY) phase = PH_UNKNOWN;
        end
        PH_HEAD: head(o, b, lst);
        PH_QSRC: if (o[1:0] == 3) begin
          put(F_SRC_ADDR, acc, o - 3);
          srcs = srcs - 1;
          if (srcs == 0) phase = PH_TRAIL;
        end
        PH_RHA: begin
          if (o[1:0] == 0) begin
            if (b < 1 || b > 6) bad = 1;
            put(F_REC_START, recs, o); put(F_REC_TYPE, b, o);
          end else if (o[1:0] == 1) begin
            aux = {b, 2'b00};
            put(F_AUX_LEN, aux, o);
          end else if (o[1:0] == 3) begin
            srcs = acc[15:0];
            put(F_REC_NSRC, srcs, o - 1);
            phase = PH_RHB;
          end
        end
        PH_RHB: if (o[1:0] == 3) begin
          put(F_REC_GROUP, acc, o - 3);
          if (srcs != 0) phase = PH_RSRC;
          else src_done();
        end
        PH_RSRC: if (o[1:0] == 3) begin
          put(F_REC_SRC, acc, o - 3);
          srcs = srcs - 1;
          if (srcs == 0) src_done();
        end
        PH_RAUX: begin
          put(F_AUX_BYTE, b, o);
          aux = aux - 1;
          if (aux == 0) rec_done();
        end
        PH_TRAIL: begin
          bad = 1; put(F_TRAILING, b, o);
        end
        default: put(F_TRAILING, b, o);
      endcase
    endfunction

    // Note one accepted request and queue the fields it completes
    function void note_byte(logic [7:0] b, logic lst);
      logic [31:0] o, s;
      logic ok;
      o = off;
      run.delete();
      if (stopped) bad = 1;
      else begin
        if (o < 12) hold[o] = b;
        sum = sum + (o[0] ? {24'd0, b} : {16'd0, b, 8'd0});
        sum = (sum & 32'hFFFF) + (sum >> 16);
        acc = {acc[23:0], b};
        parse(o, b, lst);
      end
      if (lst) begin
        if (stopped || !(phase == PH_TRAIL || phase == PH_UNKNOWN)) bad = 1;
        else if (phase == PH_TRAIL) begin
          s = sum;
          s = (s & 32'hFFFF) + (s >> 16);
          s = (s & 32'hFFFF) + (s >> 16);
          ok = (s == 32'hFFFF);
          if (!ok) bad = 1;
          put(F_CSUM_OK, ok, 2);
        end
        put(F_END, o + 1, o);
        clear_msg();
      end else if (!stopped) begin
        if (o >= OFF_LAST) stopped = 1;
        else off = o + 1;
      end
      if (run.size() > 0) run[run.size() - 1].is_last = 1;
      foreach (run[i]) pending.push_back(run[i]);
    endfunction

    // Compare one accepted result with the oldest pending field
    function void check(logic [55:0] d, logic lst);
      field_t e, a;
      a.code = d[4:0]; a.value = d[36:5]; a.offset = d[52:37];
      a.malformed = d[53]; a.is_last = lst;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result code=%0d value=%h off=%0d", a.code, a.value, a.offset);
        end
        return;
      end
      e = pending.pop_front();
      if (e !== a || d[55:54] !== 2'b00) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch exp code=%0d val=%h off=%0d mal=%b last=%b",
                   e.code, e.value, e.offset, e.malformed, e.is_last);
          $display("         got code=%0d val=%h off=%0d mal=%b last=%b",
                   a.code, a.value, a.offset, a.malformed, a.is_last);
        end
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tlast;
  logic [7:0]  s_tdata;
  logic        m_tvalid, m_tready, m_tlast;
  logic [55:0] m_tdata;

  field_board board;
  int  send_idle, recv_idle;
  bit  hold_recv;
  int  stall_cnt;
  bit  done;
  logic [7:0] msg[$];

  igmp_packet_field_parser_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stall, long hold-off when asked
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_recv) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle);
    if (!rst && m_tvalid && m_tready) board.check(m_tdata, m_tlast);
  end

  // Watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WD_LIMIT && !done) begin
      $display("** igmp_packet_field_parser_unit: FAILED **");
      $finish;
    end
  end

  // Send the first byte of a message, with optional idle gap first
  task automatic send_byte(logic [7:0] b, logic lst);
    while ($urandom_range(99) < send_idle) begin
      @(posedge clk);
      s_tvalid <= 1'b0;
    end
    @(posedge clk);
    s_tvalid <= 1'b1; s_tdata <= b; s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
    board.note_byte(b, lst);
  endtask

  task automatic send_msg();
    foreach (msg[i]) begin
      if (i == 0) send_byte(msg[i], msg.size() == 1);
      else begin
        // tvalid stays high between bytes unless an idle gap is drawn: the next byte goes out on the same edge
        while ($urandom_range(99) < send_idle) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
        end
        s_tvalid <= 1'b1; s_tdata <= msg[i]; s_tlast <= (i == msg.size() - 1);
        do @(posedge clk); while (!s_tready);
        board.note_byte(msg[i], i == msg.size() - 1);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic add32(logic [31:0] w);
    msg.push_back(w[31:24]); msg.push_back(w[23:16]);
    msg.push_back(w[15:8]); msg.push_back(w[7:0]);
  endtask

  // Patch bytes 2..3 so the ones'-complement sum comes out right
  task automatic fix_sum();
    logic [31:0] s;
    s = 0;
    msg[2] = 0; msg[3] = 0;
    foreach (msg[i]) begin
      s = s + (i[0] ? {24'd0, msg[i]} : {16'd0, msg[i], 8'd0});
      s = (s & 32'hFFFF) + (s >> 16);
    end
    s = ~s;
    msg[2] = s[15:8]; msg[3] = s[7:0];
  endtask

  task automatic build(int kind, bit good_sum);
    int n, r, k, a;
    msg.delete();
    case (kind)
      0: begin // v1/v2 query
        msg.push_back(T_QUERY); msg.push_back($urandom_range(1) ? 8'd0 : 8'($urandom));
        msg.push_back(8'd0); msg.push_back(8'd0); add32($urandom);
      end
      1: begin // v3 query
        n = $urandom_range(3);
        msg.push_back(T_QUERY); msg.push_back(8'($urandom));
        msg.push_back(8'd0); msg.push_back(8'd0);
        add32($urandom);
        msg.push_back($urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(15)));
        msg.push_back(8'($urandom)); msg.push_back(8'd0); msg.push_back(8'(n));
        for (int i = 0; i < n; i++) add32($urandom);
      end
      2: begin // v1/v2 report or leave
        k = $urandom_range(2);
        msg.push_back(k == 0 ? T_V1_REPORT : k == 1 ? T_V2_REPORT : T_LEAVE);
        msg.push_back($urandom_range(5) == 0 ? 8'($urandom) : 8'd0);
        msg.push_back(8'd0); msg.push_back(8'd0); add32($urandom);
      end
      3: begin // v3 report
        r = $urandom_range(2);
        msg.push_back(T_V3_REPORT); msg.push_back(8'd0); msg.push_back(8'd0);
        msg.push_back(8'd0); msg.push_back(8'd0);
        msg.push_back($urandom_range(7) == 0 ? 8'd1 : 8'd0);
        msg.push_back(8'd0); msg.push_back(8'(r));
        for (int j = 0; j < r; j++) begin
          n = $urandom_range(2); a = ($urandom_range(3) == 0);
          msg.push_back($urandom_range(7) == 0 ? 8'($urandom) : 8'($urandom_range(1, 6)));
          msg.push_back(8'(a)); msg.push_back(8'd0); msg.push_back(8'(n));
          add32($urandom);
          for (int i = 0; i < n; i++) add32($urandom);
          for (int i = 0; i < 4 * a; i++) msg.push_back(8'($urandom));
        end
      end
      default: begin // unknown type
        n = $urandom_range(1, 6);
        do k = $urandom_range(255); while (k inside {8'h11, 8'h12, 8'h16, 8'h17, 8'h22});
        msg.push_back(8'(k));
        for (int i = 1; i < n; i++) msg.push_back(8'($urandom));
      end
    endcase
    if (kind <= 3) begin
      fix_sum();
      if (!good_sum) msg[3] = msg[3] ^ 8'h01;
    end
  endtask

  task automatic rand_msg();
    int kind, cut;
    kind = $urandom_range(4);
    build(kind, $urandom_range(7) != 0);
    cut = $urandom_range(9);
    if (cut == 0 && msg.size() > 1) msg = msg[0:$urandom_range(msg.size() - 2)];
    else if (cut == 1) msg.push_back(8'($urandom));
    send_msg();
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (board.pending.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
  endtask

  initial begin
    board = new();
    rst = 1; s_tvalid = 0; s_tdata = 0; s_tlast = 0;
    hold_recv = 0; done = 0; send_idle = 0; recv_idle = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // Directed: query, report and unknown types, extreme codes, truncation, extra byte, bad sum
    msg = '{T_QUERY, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    fix_sum(); send_msg();
    msg = '{T_QUERY, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'hFF, 8'hFF, 8'h00, 8'h01, 8'hAA, 8'h55, 8'hAA, 8'h55};
    fix_sum(); send_msg();
    build(3, 1); send_msg();
    build(2, 0); send_msg();
    msg = '{T_V3_REPORT, 8'h00, 8'h00}; send_msg();
    build(2, 1); msg.push_back(8'h7E); send_msg();
    msg = '{8'h00, 8'hFF}; send_msg();
    msg = '{8'h80}; send_msg();

    // Receiver holds off while the sender keeps pushing
    fork
      begin
        hold_recv = 1;
        repeat (300) @(posedge clk);
        hold_recv = 0;
      end
      begin
        for (int i = 0; i < 2; i++) begin
          build(1, 1); send_msg();
        end
      end
    join
    drain();

    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 23 : (p == 1) ? 85 : 0;
      recv_idle = (p == 0) ? 85 : (p == 1) ? 23 : 0;
      for (int i = 0; i < 3; i++) rand_msg();
    end
    send_idle = 0; recv_idle = 0;

    drain();
    done = 1;
    if (board.errors == 0 && board.pending.size() == 0)
      $display("** igmp_packet_field_parser_unit: PASSED **");
    else
      $display("** igmp_packet_field_parser_unit: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
